// File: hdl/ale_pkg.sv
// Package for the array list engine: opcodes and the cell control word.
// No dependencies; used by ale_cell, array_list_engine_core and tb_top.
package ale_pkg;

  localparam logic [3:0] OP_INS_SORTED = 4'd0;
  localparam logic [3:0] OP_INS_FIRST  = 4'd1;
  localparam logic [3:0] OP_INS_LAST   = 4'd2;
  localparam logic [3:0] OP_INS_AT     = 4'd3;
  localparam logic [3:0] OP_DEL_FIRST  = 4'd4;
  localparam logic [3:0] OP_DEL_LAST   = 4'd5;
  localparam logic [3:0] OP_DEL_AT     = 4'd6;
  localparam logic [3:0] OP_DEL_FMATCH = 4'd7;
  localparam logic [3:0] OP_DEL_LMATCH = 4'd8;
  localparam logic [3:0] OP_DEL_ALL    = 4'd9;
  localparam logic [3:0] OP_CONTAINS   = 4'd10;
  localparam logic [3:0] OP_FIND       = 4'd11;
  localparam logic [3:0] OP_COUNT      = 4'd12;
  localparam logic [3:0] OP_CLEAR      = 4'd13;

  // Per-cycle command word, one for each cell.
  typedef struct packed {
    logic        load;   // hold word from left neighbor (shift right)
    logic        pull;   // take word from right neighbor (shift left)
    logic        put;    // write the new value
  } cell_ctl_t;

endpackage

// File: hdl/ale_cell.sv
// One storage cell of the list: holds one 32-bit entry and moves it to a
// neighbor on command. Depends on ale_pkg.
module ale_cell import ale_pkg::*; (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] left_word,
  input  logic signed [31:0] right_word,
  input  logic signed [31:0] new_word,
  output logic signed [31:0] word
);

  always_ff @(posedge clk) begin
    if (ctl.put) begin
      word <= new_word;
    end else if (ctl.load) begin
      word <= left_word;
    end else if (ctl.pull) begin
      word <= right_word;
    end
  end

endmodule

// File: hdl/array_list_engine_core.sv
// Array list engine top level: a row of CAPACITY cells plus a sequencer.
// Length-only ops and rejected ops go from accept straight to the result;
// insert/delete at a known place go through ST_SCAN first; scans, sorted
// inserts and compactions stay in ST_SCAN until the walk ends. One word is in
// flight at a time, so a new word is taken only after the result has been accepted. Searches
// step one position per cycle; shifts move the whole row in parallel. Reset (rst, synchronous) empties the list.
module array_list_engine_core import ale_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // opcode[3:0], value[35:4], position_in[42:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // ok[0], position_out[6:1], occurrences[13:7],
                                 // length[20:14]
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [3:0]        op;
  logic signed [31:0] val;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     idx;      // scan pointer
  logic [CW-1:0]     wr;       // compaction write pointer
  logic [CW-1:0]     hits;
  logic [CW-1:0]     first_pos;
  logic [CW-1:0]     last_pos;
  logic              found;
  logic              r_ok;
  logic [5:0]        r_pos;
  logic [6:0]        r_occ;

  logic signed [31:0] words [CAPACITY];
  cell_ctl_t          ctl   [CAPACITY];
  logic signed [31:0] new_word;
  logic [CW-1:0]      ins_at;
  logic [CW-1:0]      del_at;
  logic               do_ins;
  logic               do_del;
  logic               cmp_do;  // compaction copy
  logic signed [31:0] rd;

  logic [3:0]         op_in;
  logic [6:0]         pos_in;
  logic [CW-1:0]      start_idx;
  logic [1:0]         start_state;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata  = {3'd0, 7'(cnt), r_occ, r_pos, r_ok};
  assign rd       = words[idx[IW-1:0]];
  assign op_in    = s_tdata[3:0];
  assign pos_in   = s_tdata[42:36];

  // Row of cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lw, rw;
    if (g == 0) begin : g_l0
      assign lw = '0;
    end else begin : g_ln
      assign lw = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_rl
      assign rw = '0;
    end else begin : g_rn
      assign rw = words[g+1];
    end
    always_comb begin
      ctl[g].put  = (do_ins && CW'(g) == ins_at) ||
                    (cmp_do && CW'(g) == wr);
      ctl[g].load = do_ins && CW'(g) > ins_at && CW'(g) <= cnt;
      ctl[g].pull = do_del && CW'(g) >= del_at && CW'(g) + 1 < cnt;
    end
    ale_cell u_cell (
      .clk(clk), .ctl(ctl[g]), .left_word(lw), .right_word(rw),
      .new_word(new_word), .word(words[g])
    );
  end

  // Starting pointer and first state for an accepted word; rejects and the
  // length-only ops (delete last, clear) go straight to the result.
  always_comb begin
    start_idx   = '0;
    start_state = ST_SCAN;
    case (op_in)
      OP_INS_SORTED, OP_INS_LAST: begin
        start_idx = cnt;
        if (cnt >= CW'(CAPACITY)) start_state = ST_DONE;
      end
      OP_INS_FIRST: begin
        if (cnt >= CW'(CAPACITY)) start_state = ST_DONE;
      end
      OP_INS_AT: begin
        start_idx = CW'(pos_in);
        if (cnt >= CW'(CAPACITY) || 32'(pos_in) > 32'(cnt)) start_state = ST_DONE;
      end
      OP_DEL_FIRST: begin
        if (cnt == '0) start_state = ST_DONE;
      end
      OP_DEL_AT: begin
        start_idx = CW'(pos_in);
        if (32'(pos_in) >= 32'(cnt)) start_state = ST_DONE;
      end
      OP_DEL_FMATCH, OP_DEL_LMATCH, OP_DEL_ALL,
      OP_CONTAINS, OP_FIND, OP_COUNT: ;
      default: start_state = ST_DONE;
    endcase
  end

  // Sequencer decode: insert/delete fire in the same cycle that the place is known.
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    cmp_do   = 1'b0;
    ins_at   = '0;
    del_at   = '0;
    new_word = val;
    if (state == ST_SCAN) begin
      case (op)
        OP_INS_SORTED: begin
          // scan from back: idx counts down
          if (idx == 0 || words[IW'(idx - 1)] <= val) begin
            do_ins = 1'b1;
            ins_at = idx;
          end
        end
        OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
          do_ins = 1'b1;
          ins_at = idx;
        end
        OP_DEL_FIRST, OP_DEL_AT: begin
          do_del = 1'b1;
          del_at = idx;
        end
        OP_DEL_FMATCH, OP_DEL_LMATCH: begin
          if (idx >= cnt) begin
            do_del = found;
            del_at = (op == OP_DEL_FMATCH) ? first_pos : last_pos;
          end
        end
        OP_DEL_ALL: begin
          if (idx < cnt && rd != val) begin
            cmp_do   = 1'b1;
            new_word = rd;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op    <= op_in;
            val   <= s_tdata[35:4];
            r_ok  <= (op_in == OP_CLEAR) || (op_in == OP_DEL_LAST && cnt != '0);
            r_pos <= '0;
            r_occ <= '0;
            hits  <= '0;
            found <= 1'b0;
            first_pos <= '0;
            last_pos  <= '0;
            wr    <= '0;
            idx   <= start_idx;
            state <= start_state;
            if (op_in == OP_CLEAR)
              cnt <= '0;
            else if (op_in == OP_DEL_LAST && cnt != '0)
              cnt <= cnt - 1'b1;
          end
        end
        ST_SCAN: begin
          if (do_ins) begin
            cnt   <= cnt + 1'b1;
            r_ok  <= 1'b1;
            state <= ST_DONE;
          end else if (op == OP_INS_SORTED) begin
            idx <= idx - 1'b1;
          end else if (do_del) begin
            cnt   <= cnt - 1'b1;
            r_ok  <= 1'b1;
            state <= ST_DONE;
          end else if (idx >= cnt) begin
            // end of scan
            state <= ST_DONE;
            case (op)
              OP_DEL_ALL: begin
                cnt  <= wr;
                r_ok <= found;
              end
              OP_CONTAINS: r_ok <= found;
              OP_FIND: begin
                r_ok  <= found;
                r_pos <= 6'(first_pos);
              end
              OP_COUNT: begin
                r_ok  <= (hits != 0);
                r_occ <= 7'(hits);
              end
              default: ;
            endcase
          end else begin
            idx <= idx + 1'b1;
            if (rd == val) begin
              if (!found) first_pos <= idx;
              last_pos <= idx;
              found    <= 1'b1;
              hits     <= hits + 1'b1;
            end
            if (cmp_do) wr <= wr + 1'b1;
          end
        end
        ST_DONE: begin
          if (m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY)) else $error("count above capacity");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("accept while result pending");
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> cnt == $past(cnt) + 1'b1) else $error("insert did not grow list");
  a_del_shrink: assert property (@(posedge clk) disable iff (rst)
    do_del |=> cnt == $past(cnt) - 1'b1) else $error("delete did not shrink list");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for array_list_engine_core: random and directed list operations, predicted
// against a behavioral copy of the list. Depends on ale_pkg and array_list_engine_core.
module tb_top;
  import ale_pkg::*;

  localparam int CAP = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [6:0]  pos;
    logic [31:0] value;
    logic [3:0]  opcode;
  } list_cmd_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] pos;
    logic [6:0] occ;
    logic [6:0] len;
  } list_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  array_list_engine_core #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow list
  logic signed [31:0] shadow [CAP];
  int                 shadow_len = 0;

  list_cmd_t  pending_cmds[$];
  list_resp_t expected_resps[$];
  int         errors = 0;
  int         words_sent = 0;
  int         words_recv = 0;
  int         idle_cycles = 0;
  int         op_hits [16];
  bit         hold_sender = 1'b0;
  bit         long_stall_req = 1'b0;
  bit         in_taken = 1'b0;

  function automatic list_resp_t apply_cmd(list_cmd_t c);
    list_resp_t r;
    int i, n, p;
    logic signed [31:0] v;
    r = '0;
    v = c.value;
    p = c.pos;
    case (c.opcode)
      OP_INS_SORTED: if (shadow_len < CAP) begin
        i = shadow_len;
        while (i > 0 && shadow[i-1] > v) begin
          shadow[i] = shadow[i-1];
          i--;
        end
        shadow[i] = v;
        shadow_len++;
        r.ok = 1;
      end
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (c.opcode == OP_INS_FIRST) p = 0;
        else if (c.opcode == OP_INS_LAST) p = shadow_len;
        if (p <= shadow_len && shadow_len < CAP) begin
          for (i = shadow_len; i > p; i--) shadow[i] = shadow[i-1];
          shadow[p] = v;
          shadow_len++;
          r.ok = 1;
        end
      end
      OP_DEL_FIRST, OP_DEL_AT, OP_DEL_LAST: begin
        if (c.opcode == OP_DEL_FIRST) p = 0;
        else if (c.opcode == OP_DEL_LAST) p = shadow_len - 1;
        if (shadow_len > 0 && p < shadow_len) begin
          for (i = p; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
          shadow_len--;
          r.ok = 1;
        end
      end
      OP_DEL_FMATCH, OP_DEL_LMATCH: begin
        p = -1;
        for (i = 0; i < shadow_len; i++)
          if (shadow[i] == v && (p < 0 || c.opcode == OP_DEL_LMATCH)) p = i;
        if (p >= 0) begin
          for (i = p; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
          shadow_len--;
          r.ok = 1;
        end
      end
      OP_DEL_ALL: begin
        n = 0;
        for (i = 0; i < shadow_len; i++)
          if (shadow[i] != v) begin
            shadow[n] = shadow[i];
            n++;
          end else begin
            r.ok = 1;
          end
        shadow_len = n;
      end
      OP_CONTAINS, OP_FIND: begin
        for (i = shadow_len - 1; i >= 0; i--)
          if (shadow[i] == v) begin
            r.ok = 1;
            if (c.opcode == OP_FIND) r.pos = i[5:0];
          end
      end
      OP_COUNT: begin
        n = 0;
        for (i = 0; i < shadow_len; i++) if (shadow[i] == v) n++;
        r.occ = n[6:0];
        r.ok = n > 0;
      end
      OP_CLEAR: begin
        shadow_len = 0;
        r.ok = 1;
      end
      default: ;
    endcase
    r.len = shadow_len[6:0];
    return r;
  endfunction

  // Sender: bursts with random gaps, inputs change on the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // hold the word
    end else if (!hold_sender && pending_cmds.size() > 0 && gap_left == 0) begin
      s_tdata  <= {5'd0, pending_cmds[0]};
      s_tvalid <= 1'b1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_tvalid <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end
  end

  // Receiver: stall pattern, with occasional long hold-offs on request
  int stall_mode = 0;
  int long_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_stall_req && long_left == 0) begin
      long_left <= 400;
      m_tready <= 1'b0;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      m_tready <= (long_left == 1);
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Accepts and checks at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        list_cmd_t c;
        c = s_tdata[42:0];
        expected_resps.push_back(apply_cmd(c));
        pending_cmds.pop_front();
        op_hits[c.opcode]++;
        words_sent++;
      end
      if (m_tvalid && m_tready) begin
        list_resp_t got, want;
        got = {m_tdata[0], m_tdata[6:1], m_tdata[13:7], m_tdata[20:14]};
        words_recv++;
        if (expected_resps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = expected_resps.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: ok %b/%b pos %0d/%0d occ %0d/%0d len %0d/%0d",
                       words_recv, want.ok, got.ok, want.pos, got.pos,
                       want.occ, got.occ, want.len, got.len);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
        $display("FAIL array_list_engine_core");
        $finish;
      end
    end
  end

  function automatic list_cmd_t make_cmd(logic [3:0] op, logic [31:0] v, logic [6:0] p);
    list_cmd_t c;
    c.opcode = op;
    c.value = v;
    c.pos = p;
    return c;
  endfunction

  // Values mostly from a tiny pool so matches happen often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 7) - 4;
    endcase
  endfunction

  task automatic wait_drain();
    while (pending_cmds.size() > 0 || expected_resps.size() > 0) @(posedge clk);
  endtask

  initial begin
    list_cmd_t c;
    int k, op, fill_bias;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-list failures, extremes, fill to full, overflow, all ops
    pending_cmds.push_back(make_cmd(OP_DEL_FIRST, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_LAST, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_AT, 0, 7'h7f));
    pending_cmds.push_back(make_cmd(OP_FIND, 5, 0));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 9, 1));
    pending_cmds.push_back(make_cmd(OP_INS_SORTED, 32'h7fff_ffff, 0));
    pending_cmds.push_back(make_cmd(OP_INS_SORTED, 32'h8000_0000, 0));
    pending_cmds.push_back(make_cmd(OP_INS_SORTED, 32'hffff_ffff, 0));
    pending_cmds.push_back(make_cmd(OP_INS_SORTED, 32'hffff_ffff, 0));
    pending_cmds.push_back(make_cmd(OP_INS_FIRST, 3, 0));
    pending_cmds.push_back(make_cmd(OP_INS_LAST, 3, 0));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 3, 6));
    pending_cmds.push_back(make_cmd(OP_CONTAINS, 32'hffff_ffff, 0));
    pending_cmds.push_back(make_cmd(OP_FIND, 3, 0));
    pending_cmds.push_back(make_cmd(OP_COUNT, 3, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_FMATCH, 3, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_LMATCH, 3, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_ALL, 32'hffff_ffff, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_FMATCH, 77, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_AT, 0, 1));
    pending_cmds.push_back(make_cmd(4'd14, 0, 0));
    pending_cmds.push_back(make_cmd(4'd15, 32'hffff_ffff, 7'h7f));
    for (k = 0; k < 66; k++) pending_cmds.push_back(make_cmd(OP_INS_LAST, k % 5, 0));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 1, 64));
    pending_cmds.push_back(make_cmd(OP_FIND, 4, 0));
    pending_cmds.push_back(make_cmd(OP_COUNT, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DEL_AT, 0, 63));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 1, 63));
    pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0));
    wait_drain();

    // Random phases; each phase biases toward growth or shrinkage
    for (int ph = 0; ph < 10; ph++) begin
      fill_bias = $urandom_range(2, 8);
      for (k = 0; k < 95; k++) begin
        if ($urandom_range(0, 9) < fill_bias) op = $urandom_range(0, 3);
        else if ($urandom_range(0, 40) == 0) op = $urandom_range(13, 15);
        else op = $urandom_range(4, 12);
        c = make_cmd(op[3:0], pick_value(),
                     7'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 65)));
        pending_cmds.push_back(c);
      end
      if (ph == 3) begin
        // let the sender run ahead while the receiver holds off
        repeat (5) @(posedge clk);
        long_stall_req = 1'b1;
        @(posedge clk);
        long_stall_req = 1'b0;
      end
      if (ph == 6) begin
        hold_sender = 1'b1;
        while (expected_resps.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d operations, %0d results; final list length %0d",
             words_sent, words_recv, shadow_len);
    $display("op mix: ins %0d/%0d/%0d/%0d del %0d/%0d/%0d match %0d/%0d/%0d q %0d/%0d/%0d clr %0d",
             op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
             op_hits[6], op_hits[7], op_hits[8], op_hits[9], op_hits[10], op_hits[11],
             op_hits[12], op_hits[13]);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("PASS array_list_engine_core");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL array_list_engine_core");
    end
    $finish;
  end

endmodule

// File: array_list_engine_core.f
hdl/ale_pkg.sv
hdl/ale_cell.sv
hdl/array_list_engine_core.sv
sim/tb_top.sv
